### sv/deadlock_detector_macros.svh
// Assertion macros shared by the deadlock detector RTL.
`ifndef DEADLOCK_DETECTOR_MACROS_SVH
`define DEADLOCK_DETECTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deadlock_detector: same-cycle check failed");
`define DD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deadlock_detector: next-cycle check failed");
`else
`define DD_ASSERT_IMP(lbl, ante, cons)
`define DD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### sv/dd_pkg.sv
// Shared types and codes of the deadlock detector.
`default_nettype none
package dd_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_AVAIL = 2'd0,
    OP_LOAD_ALLOC = 2'd1,
    OP_LOAD_REQ   = 2'd2,
    OP_RUN        = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_REPORT = 2'd2
  } state_e;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_PROC_COUNT = 2'd0;
  localparam logic [1:0] REG_RES_COUNT  = 2'd1;

  // Per-cycle control handed from the sequencer to every resource cell.
  typedef struct packed {
    logic load_avail;
    logic load_alloc;
    logic load_req;
    logic release_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### sv/dd_cell.sv
// One resource cell: available count plus its allocation and request columns.
`default_nettype none
module dd_cell #(
  parameter int MAX_PROCS  = 16,
  parameter int VALUE_BITS = 16,
  parameter int PIW        = 4
) (
  input  wire                       clk_i,
  input  dd_pkg::cell_ctrl_t        ctrl_i,
  input  wire  [PIW-1:0]            wr_addr_i,
  input  wire  [VALUE_BITS-1:0]     wr_data_i,
  input  wire  [PIW-1:0]            rd_addr_i,
  input  wire                       active_i,
  input  wire                       ok_i,
  output logic                      ok_o
);

  logic [VALUE_BITS-1:0] avail_q;
  logic [VALUE_BITS-1:0] alloc_mem [MAX_PROCS];
  logic [VALUE_BITS-1:0] req_mem   [MAX_PROCS];
  logic [VALUE_BITS-1:0] alloc_rd;
  logic [VALUE_BITS-1:0] req_rd;
  logic [VALUE_BITS:0]   sum;
  logic [VALUE_BITS-1:0] avail_d;

  assign alloc_rd = alloc_mem[rd_addr_i];
  assign req_rd   = req_mem[rd_addr_i];

  // The request test ripples along the row; inactive resources pass it on.
  assign ok_o = ok_i & (~active_i | (req_rd <= avail_q));

  // Saturating release of the allocation into the available count.
  always_comb begin
    sum = {1'b0, avail_q} + {1'b0, alloc_rd};
    if (sum[VALUE_BITS]) begin
      avail_d = '1;
    end else begin
      avail_d = sum[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_avail) begin
      avail_q <= wr_data_i;
    end else if (ctrl_i.release_en && active_i) begin
      avail_q <= avail_d;
    end
    if (ctrl_i.load_alloc) begin
      alloc_mem[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.load_req) begin
      req_mem[wr_addr_i] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

### sv/deadlock_detector.sv
// Load: a transaction is taken whenever the detector is idle, with no result. Run: the
// processes are scanned in order, pass after pass, at most np passes, and the result
// strobe follows; with zero processes the result comes in the cycle after start. The
// scan takes one process a cycle through the row of resource cells, and the next
// transaction is taken in the cycle after the strobe on done_o; the receiver cannot stall.
// Reset clears the control state and sets the counts to their maxima; stores are undefined.
`default_nettype none
`include "deadlock_detector_macros.svh"
module deadlock_detector #(
  parameter int MAX_PROCS  = 16,
  parameter int MAX_RES    = 8,
  parameter int VALUE_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire  [1:0]  operation_i,
  input  wire  [3:0]  proc_index_i,
  input  wire  [2:0]  res_index_i,
  input  wire  [15:0] value_i,
  output logic        done_o,
  output logic [4:0]  deadlocked_count_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [4:0]  cfg_data_i
);

  localparam int PCW = $clog2(MAX_PROCS + 1);
  localparam int PIW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int NRW = $clog2(MAX_RES + 1);

  dd_pkg::state_e        state_q, state_d;
  logic [4:0]            proc_count_q;
  logic [3:0]            res_count_q;
  logic [PCW-1:0]        np;
  logic [NRW-1:0]        nr;
  logic [PCW-1:0]        p_q;
  logic [PCW-1:0]        total_q;
  logic [PCW-1:0]        total_nx;
  logic                  prog_q;
  logic                  prog_nx;
  logic [MAX_PROCS-1:0]  fin_q;
  logic [PIW-1:0]        p_idx;
  logic                  accept;
  logic                  pidx_ok;
  logic                  ridx_ok;
  logic [VALUE_BITS+15:0] val_ext;
  logic [VALUE_BITS-1:0] wr_data;
  logic [PIW-1:0]        wr_addr;
  logic [MAX_RES:0]      ok_chain;
  logic                  cand;
  logic                  last_proc;
  logic                  more_passes;

  // Effective counts, clamped to the array sizes.
  always_comb begin
    np = (32'(proc_count_q) > MAX_PROCS) ? PCW'(MAX_PROCS) : PCW'(proc_count_q);
    nr = (32'(res_count_q) > MAX_RES) ? NRW'(MAX_RES) : NRW'(res_count_q);
  end

  // Configuration writes.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_count_q <= 5'd16;
      res_count_q  <= 4'd8;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == dd_pkg::REG_PROC_COUNT) begin
        proc_count_q <= cfg_data_i;
      end else if (cfg_index_i == dd_pkg::REG_RES_COUNT) begin
        res_count_q <= cfg_data_i[3:0];
      end
    end
  end

  // Load decode.
  assign accept  = start_i & ~busy_o;
  assign pidx_ok = 32'(proc_index_i) < MAX_PROCS;
  assign ridx_ok = 32'(res_index_i) < MAX_RES;
  assign val_ext = {{VALUE_BITS{1'b0}}, value_i};
  assign wr_data = val_ext[VALUE_BITS-1:0];
  assign wr_addr = PIW'(proc_index_i);
  assign p_idx   = p_q[PIW-1:0];

  // Scan step: the current process finishes if every active request fits.
  assign cand        = (state_q == dd_pkg::S_SCAN) && !fin_q[p_idx] && ok_chain[MAX_RES];
  assign total_nx    = total_q + PCW'(cand);
  assign prog_nx     = prog_q | cand;
  assign last_proc   = (p_q == np - PCW'(1));
  assign more_passes = (total_nx < np) && prog_nx;

  // Row of resource cells.
  assign ok_chain[0] = 1'b1;
  for (genvar r = 0; r < MAX_RES; r++) begin : g_cell
    dd_pkg::cell_ctrl_t ctrl;
    logic               hit;
    assign hit             = ridx_ok && (32'(res_index_i) == r);
    assign ctrl.load_avail = accept && (operation_i == dd_pkg::OP_LOAD_AVAIL) && hit;
    assign ctrl.load_alloc = accept && (operation_i == dd_pkg::OP_LOAD_ALLOC) && hit && pidx_ok;
    assign ctrl.load_req   = accept && (operation_i == dd_pkg::OP_LOAD_REQ) && hit && pidx_ok;
    assign ctrl.release_en = cand;
    dd_cell #(
      .MAX_PROCS (MAX_PROCS),
      .VALUE_BITS(VALUE_BITS),
      .PIW       (PIW)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .wr_addr_i(wr_addr),
      .wr_data_i(wr_data),
      .rd_addr_i(p_idx),
      .active_i (32'(nr) > r),
      .ok_i     (ok_chain[r]),
      .ok_o     (ok_chain[r+1])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dd_pkg::S_IDLE: begin
        if (accept && (operation_i == dd_pkg::OP_RUN)) begin
          state_d = (np == '0) ? dd_pkg::S_REPORT : dd_pkg::S_SCAN;
        end
      end
      dd_pkg::S_SCAN: begin
        if (last_proc && !more_passes) begin
          state_d = dd_pkg::S_REPORT;
        end
      end
      dd_pkg::S_REPORT: state_d = dd_pkg::S_IDLE;
      default:          state_d = dd_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy_o             = (state_q != dd_pkg::S_IDLE);
    done_o             = (state_q == dd_pkg::S_REPORT);
    deadlocked_count_o = 5'(np - total_q);
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dd_pkg::S_IDLE;
      p_q     <= '0;
      total_q <= '0;
      prog_q  <= 1'b0;
      fin_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        dd_pkg::S_IDLE: begin
          p_q     <= '0;
          total_q <= '0;
          prog_q  <= 1'b0;
        end
        dd_pkg::S_SCAN: begin
          total_q <= total_nx;
          if (cand) begin
            fin_q[p_idx] <= 1'b1;
          end
          if (last_proc) begin
            p_q    <= '0;
            prog_q <= 1'b0;
          end else begin
            p_q    <= p_q + PCW'(1);
            prog_q <= prog_nx;
          end
        end
        dd_pkg::S_REPORT: begin
          fin_q   <= '0;
          total_q <= '0;
          prog_q  <= 1'b0;
        end
        default: begin
          fin_q <= '0;
        end
      endcase
    end
  end

  // Checks.
  `DD_ASSERT_IMP(a_count_range, done_o, total_q <= np)
  `DD_ASSERT_IMP(a_scan_total, state_q == dd_pkg::S_SCAN, total_q <= np)
  `DD_ASSERT_NXT(a_done_idle, done_o, !busy_o && (fin_q == '0))
  `DD_ASSERT_NXT(a_run_busy, accept && (operation_i == dd_pkg::OP_RUN), busy_o)

endmodule
`default_nettype wire
